/* rtl/core/btop_pkg.sv */
package btop_pkg;

  localparam int unsigned MAX_STEPS_DEF = 1024;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STRIKE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROB     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DISC     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CALL     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_AMERICAN = 3'd7;

  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [30:0] HALF_Q30 = 31'h2000_0000;

  typedef struct packed {
    logic        en;
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

  // Round a Q30-scaled product to nearest, ties up, and saturate to 32 bits.
  function automatic logic [31:0] rnd_sat_q30(input logic [63:0] prod);
    logic [63:0] sum;
    logic [33:0] sh;
    sum = prod + 64'(HALF_Q30);
    sh  = sum[63:30];
    if (sh[33:32] != 2'b00) begin
      return 32'hFFFF_FFFF;
    end
    return sh[31:0];
  endfunction

  function automatic logic [31:0] payoff(input logic [31:0] s, input logic [31:0] k,
                                         input logic call);
    if (call) begin
      return (s > k) ? (s - k) : 32'd0;
    end
    return (k > s) ? (k - s) : 32'd0;
  endfunction

endpackage

/* rtl/core/btop_mul.sv */
module btop_mul
  import btop_pkg::*;
(
  input  logic        clk_i,
  input  mul_req_t    req_i,
  output logic [63:0] prod_o
);

  logic [63:0] prod_q;

  // Register the full product; hold it while no operation is issued.
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= 64'(req_i.a) * 64'(req_i.b);
    end
  end

  assign prod_o = prod_q;

endmodule

/* rtl/core/binomial_tree_option_pricer_unit.sv */
// Channel   Direction  Handshake                       Payload
// s_axis    in         s_axis_tvalid / s_axis_tready   tdata[31:0] spot_price
// m_axis    out        m_axis_tvalid / m_axis_tready   tdata: value, seen flag, step
// cfg       in         cfg_we_i (no wait)              cfg_idx_i, cfg_data_i
//
// One item at a time. One shared 32x32 multiplier with an issue/round turn sets
// the pace, and each induction node needs four products plus a read and a write
// of the node memories.
// Reset clears the control state and the configuration; the node memories are
// not cleared, every entry is written before it is read.
// A finished result waits in the output register; a new item is taken meanwhile,
// and the block holds in its done state only if the older result is still there.
module binomial_tree_option_pricer_unit
  import btop_pkg::*;
#(
  parameter int unsigned MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,   // [31:0] spot_price
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [47:0]           m_axis_tdata,   // [31:0] option_value,
                                                // [32] early_exercise_seen,
                                                // [42:33] early_exercise_step,
                                                // [47:43] zero
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned STEP_W = $clog2(MAX_STEPS + 1);
  localparam int unsigned CMP_W  = (STEP_W > 11) ? STEP_W : 11;
  localparam int unsigned DEPTH  = MAX_STEPS + 1;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DOWN_MUL = 4'd1;
  localparam logic [3:0] ST_DOWN_RND = 4'd2;
  localparam logic [3:0] ST_TERM_PAY = 4'd3;
  localparam logic [3:0] ST_TERM_R1  = 4'd4;
  localparam logic [3:0] ST_TERM_M2  = 4'd5;
  localparam logic [3:0] ST_TERM_R2  = 4'd6;
  localparam logic [3:0] ST_IND_RD   = 4'd7;
  localparam logic [3:0] ST_IND_M1   = 4'd8;
  localparam logic [3:0] ST_IND_M2   = 4'd9;
  localparam logic [3:0] ST_IND_M3   = 4'd10;
  localparam logic [3:0] ST_IND_M4   = 4'd11;
  localparam logic [3:0] ST_IND_M5   = 4'd12;
  localparam logic [3:0] ST_IND_M6   = 4'd13;
  localparam logic [3:0] ST_IND_WR   = 4'd14;
  localparam logic [3:0] ST_DONE     = 4'd15;

  // Configuration registers
  logic [31:0] strike_q, up_q, down_q;
  logic [30:0] prob_q, disc_q;
  logic [10:0] steps_cfg_q;
  logic        call_q, amer_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strike_q    <= 32'd0;
      up_q        <= 32'(ONE_Q30);
      down_q      <= 32'(ONE_Q30);
      prob_q      <= HALF_Q30;
      disc_q      <= ONE_Q30;
      steps_cfg_q <= 11'd1;
      call_q      <= 1'b1;
      amer_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STRIKE:   strike_q    <= cfg_data_i;
        CFG_UP:       up_q        <= cfg_data_i;
        CFG_DOWN:     down_q      <= cfg_data_i;
        CFG_PROB:     prob_q      <= cfg_data_i[30:0];
        CFG_DISC:     disc_q      <= cfg_data_i[30:0];
        CFG_STEPS:    steps_cfg_q <= cfg_data_i[10:0];
        CFG_CALL:     call_q      <= cfg_data_i[0];
        CFG_AMERICAN: amer_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Clamp probability and discount at one, steps at the tree depth
  logic [30:0]       p_c, q_c, disc_c;
  logic [CMP_W-1:0]  steps_ext;
  logic [STEP_W-1:0] steps_clamped;

  always_comb begin
    p_c       = (prob_q > ONE_Q30) ? ONE_Q30 : prob_q;
    q_c       = ONE_Q30 - p_c;
    disc_c    = (disc_q > ONE_Q30) ? ONE_Q30 : disc_q;
    steps_ext = CMP_W'(steps_cfg_q);
    if (steps_ext > CMP_W'(MAX_STEPS)) begin
      steps_clamped = STEP_W'(MAX_STEPS);
    end else begin
      steps_clamped = STEP_W'(steps_ext);
    end
  end

  logic [3:0]        state_q, state_d;
  logic [STEP_W-1:0] steps_q, j_q, n_q;
  logic [31:0]       s_q, w_q, sn_q, ex_q, cont_q, root_q;
  logic [63:0]       acc_q;
  logic              seen_q;
  logic [9:0]        seen_step_q;
  logic              out_valid_q;
  logic [47:0]       out_data_q;

  logic [63:0] prod;
  mul_req_t    mreq;

  btop_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mreq),
    .prod_o (prod)
  );

  // Node memories: one write port each, values read at j and j+1
  logic [31:0]       val_mem [DEPTH];
  logic [31:0]       ast_mem [DEPTH];
  logic [31:0]       vlo_q, vhi_q, ast_rd_q;
  logic              mem_we, mem_re;
  logic [STEP_W-1:0] rd_hi_addr;
  logic [31:0]       wr_val, wr_ast;
  logic [31:0]       ind_val;
  logic              ex_wins;

  assign rd_hi_addr = j_q + STEP_W'(1);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      val_mem[j_q] <= wr_val;
      ast_mem[j_q] <= wr_ast;
    end
    if (mem_re) begin
      vlo_q    <= val_mem[j_q];
      vhi_q    <= val_mem[rd_hi_addr];
      ast_rd_q <= ast_mem[j_q];
    end
  end

  logic done_go;
  logic [31:0] term_pay;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign done_go       = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
  assign term_pay      = payoff(s_q, strike_q, call_q);
  assign ex_wins       = amer_q && (ex_q > cont_q);
  assign ind_val       = ex_wins ? ex_q : cont_q;

  always_comb begin
    state_d = state_q;
    mreq    = '{en: 1'b0, a: s_q, b: up_q};
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    wr_val  = term_pay;
    wr_ast  = s_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = (steps_clamped == '0) ? ST_TERM_PAY : ST_DOWN_MUL;
        end
      end
      ST_DOWN_MUL: begin
        mreq    = '{en: 1'b1, a: s_q, b: down_q};
        state_d = ST_DOWN_RND;
      end
      ST_DOWN_RND: begin
        state_d = (j_q == steps_q - STEP_W'(1)) ? ST_TERM_PAY : ST_DOWN_MUL;
      end
      ST_TERM_PAY: begin
        mem_we = 1'b1;
        if (j_q == steps_q) begin
          state_d = (steps_q == '0) ? ST_DONE : ST_IND_RD;
        end else begin
          mreq    = '{en: 1'b1, a: s_q, b: up_q};
          state_d = ST_TERM_R1;
        end
      end
      ST_TERM_R1: state_d = ST_TERM_M2;
      ST_TERM_M2: begin
        mreq    = '{en: 1'b1, a: s_q, b: up_q};
        state_d = ST_TERM_R2;
      end
      ST_TERM_R2: state_d = ST_TERM_PAY;
      ST_IND_RD: begin
        mem_re  = 1'b1;
        state_d = ST_IND_M1;
      end
      ST_IND_M1: begin
        mreq    = '{en: 1'b1, a: 32'(p_c), b: vhi_q};
        state_d = ST_IND_M2;
      end
      ST_IND_M2: begin
        mreq    = '{en: 1'b1, a: 32'(q_c), b: vlo_q};
        state_d = ST_IND_M3;
      end
      ST_IND_M3: begin
        mreq    = '{en: 1'b1, a: ast_rd_q, b: up_q};
        state_d = ST_IND_M4;
      end
      ST_IND_M4: state_d = ST_IND_M5;
      ST_IND_M5: begin
        mreq    = '{en: 1'b1, a: w_q, b: 32'(disc_c)};
        state_d = ST_IND_M6;
      end
      ST_IND_M6: state_d = ST_IND_WR;
      ST_IND_WR: begin
        mem_we = 1'b1;
        wr_val = ind_val;
        wr_ast = sn_q;
        if (j_q == n_q && n_q == '0) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_IND_RD;
        end
      end
      ST_DONE: begin
        if (done_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      steps_q     <= '0;
      j_q         <= '0;
      n_q         <= '0;
      seen_q      <= 1'b0;
      seen_step_q <= 10'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            steps_q     <= steps_clamped;
            j_q         <= '0;
            seen_q      <= 1'b0;
            seen_step_q <= 10'd0;
          end
        end
        ST_DOWN_RND: begin
          j_q <= (j_q == steps_q - STEP_W'(1)) ? '0 : j_q + STEP_W'(1);
        end
        ST_TERM_PAY: begin
          if (j_q == steps_q) begin
            j_q <= '0;
            n_q <= steps_q - STEP_W'(1);
          end
        end
        ST_TERM_R2: j_q <= j_q + STEP_W'(1);
        ST_IND_WR: begin
          // first win seen is the latest step, levels run from the leaves down
          if (ex_wins && !seen_q) begin
            seen_q      <= 1'b1;
            seen_step_q <= 10'(n_q);
          end
          if (j_q == n_q) begin
            j_q <= '0;
            if (n_q != '0) begin
              n_q <= n_q - STEP_W'(1);
            end
          end else begin
            j_q <= j_q + STEP_W'(1);
          end
        end
        default: ;
      endcase
      if (done_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE:     s_q <= s_axis_tdata;
      ST_DOWN_RND: s_q <= rnd_sat_q30(prod);
      ST_TERM_PAY: root_q <= term_pay;
      ST_TERM_R1:  s_q <= rnd_sat_q30(prod);
      ST_TERM_R2:  s_q <= rnd_sat_q30(prod);
      ST_IND_M2:   acc_q <= prod;
      ST_IND_M3:   acc_q <= acc_q + prod;
      ST_IND_M4: begin
        sn_q <= rnd_sat_q30(prod);
        w_q  <= rnd_sat_q30(acc_q);
      end
      ST_IND_M5:   ex_q <= payoff(sn_q, strike_q, call_q);
      ST_IND_M6:   cont_q <= rnd_sat_q30(prod);
      ST_IND_WR:   root_q <= ind_val;
      default: ;
    endcase
    if (done_go) begin
      out_data_q <= {5'd0, seen_step_q, seen_q, root_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Induction index stays inside the current level
  a_ind_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IND_RD || state_q == ST_IND_WR) |-> (j_q <= n_q && n_q < steps_q))
    else $error("induction index out of level");

  // Early exercise is only reported for an American option
  a_seen_american : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && seen_q) |-> amer_q)
    else $error("early exercise on a European option");

  // A finished item reaches the output register in the next cycle
  a_done_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_go |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished item not presented");

  // Nothing is accepted while the tree is being worked on
  a_busy_block : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready)
    else $error("input taken while busy");

endmodule

/* sim/tb_binomial_tree_option_pricer_unit.sv */
`timescale 1ns / 1ps

// Testbench for the binomial tree option pricer.
// A scoreboard prices each accepted spot price with its own copy of the tree
// and queues the expected result. A sink process compares every returned result
// field by field. Directed settings come first: reset values, zero steps,
// American puts and calls, the exercise tie, saturating and zero factors, and
// one run at the largest tree. Random settings with mostly small trees follow.
module tb_binomial_tree_option_pricer_unit;
  import btop_pkg::*;

  localparam int unsigned TREE_MAX = MAX_STEPS_DEF;

  // Expected content of one result item.
  typedef struct packed {
    logic [31:0] value;
    logic        seen;
    logic [9:0]  step;
  } pricing_t;

  // Local copy of the pricing registers, the node stores and the queue of
  // root values that the block still owes.
  class option_book;
    logic [31:0] strike;
    logic [31:0] up_f;
    logic [31:0] down_f;
    logic [30:0] prob;
    logic [30:0] disc;
    logic [10:0] steps;
    logic        is_call;
    logic        early_ok;
    bit [31:0]   node_val [TREE_MAX+1];
    bit [31:0]   node_px  [TREE_MAX+1];
    pricing_t    quotes [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned priced;

    function new();
      strike      = '0;
      up_f        = 32'(ONE_Q30);
      down_f      = 32'(ONE_Q30);
      prob        = HALF_Q30;
      disc        = ONE_Q30;
      steps       = 11'd1;
      is_call     = 1'b1;
      early_ok    = 1'b0;
      errors      = 0;
      checked     = 0;
      priced      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_STRIKE:   strike      = data;
        CFG_UP:       up_f        = data;
        CFG_DOWN:     down_f      = data;
        CFG_PROB:     prob        = data[30:0];
        CFG_DISC:     disc        = data[30:0];
        CFG_STEPS:    steps       = data[10:0];
        CFG_CALL:     is_call     = data[0];
        CFG_AMERICAN: early_ok    = data[0];
        default: ;
      endcase
    endfunction

    // Q30 product, rounded to nearest with ties up, saturated to 32 bits.
    function logic [31:0] scale_q30(logic [31:0] a, logic [31:0] f);
      logic [63:0] prod;
      prod = (64'(a) * 64'(f) + 64'(HALF_Q30)) >> 30;
      return (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
    endfunction

    function logic [31:0] gain(logic [31:0] s);
      if (is_call) begin
        return (s > strike) ? s - strike : 32'd0;
      end
      return (strike > s) ? strike - s : 32'd0;
    endfunction

    function pricing_t price(logic [31:0] spot);
      pricing_t    res;
      int unsigned n_eff;
      int unsigned row;
      int unsigned j;
      logic [63:0] p;
      logic [63:0] q;
      logic [63:0] sum;
      logic [31:0] dsc;
      logic [31:0] s;
      logic [31:0] w;
      logic [31:0] cont;
      logic [31:0] lifted;
      logic [31:0] ex;
      n_eff = (steps > TREE_MAX) ? TREE_MAX : steps;
      p     = (prob > ONE_Q30) ? 64'(ONE_Q30) : 64'(prob);
      q     = 64'(ONE_Q30) - p;
      dsc   = (disc > ONE_Q30) ? 32'(ONE_Q30) : 32'(disc);
      res   = '0;
      s     = spot;
      // Lowest terminal node: spot taken down every step.
      for (row = 0; row < n_eff; row++) begin
        s = scale_q30(s, down_f);
      end
      for (j = 0; j <= n_eff; j++) begin
        node_px[j]  = s;
        node_val[j] = gain(s);
        s = scale_q30(scale_q30(s, up_f), up_f);
      end
      // Backward induction; the first win met is the latest step.
      for (row = n_eff; row > 0; row--) begin
        for (j = 0; j < row; j++) begin
          sum    = p * node_val[j+1] + q * node_val[j];
          w      = 32'((sum + 64'(HALF_Q30)) >> 30);
          cont   = scale_q30(w, dsc);
          lifted = scale_q30(node_px[j], up_f);
          if (early_ok) begin
            ex = gain(lifted);
            if (ex > cont) begin
              if (!res.seen) begin
                res.seen = 1'b1;
                res.step = 10'(row - 1);
              end
              cont = ex;
            end
          end
          node_val[j] = cont;
          node_px[j]  = lifted;
        end
      end
      res.value = node_val[0];
      return res;
    endfunction

    function void note_spot(logic [31:0] spot);
      quotes.push_back(price(spot));
      priced++;
    endfunction

    task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 40) begin
        $display("%0t ns: mismatch in %s: got 0x%h, want 0x%h", $time, what, got, want);
      end
    endtask

    task check_result(logic [47:0] data);
      pricing_t want;
      checked++;
      if (quotes.size() == 0) begin
        flag_mismatch("result with nothing pending", data[31:0], 32'd0);
        return;
      end
      want = quotes.pop_front();
      if (data[31:0] !== want.value) flag_mismatch("option_value", data[31:0], want.value);
      if (data[32] !== want.seen) begin
        flag_mismatch("early_exercise_seen", 32'(data[32]), 32'(want.seen));
      end
      if (data[42:33] !== want.step) begin
        flag_mismatch("early_exercise_step", 32'(data[42:33]), 32'(want.step));
      end
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [47:0]           m_axis_tdata;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  option_book  book = new();
  logic [31:0] setting [8];      // register image for the next load, by index
  bit          steady;           // both sides stop idling while set
  int unsigned hold_req;         // cycles the sink must hold off, picked up once
  longint      cycle_cnt;
  longint      budget;
  int unsigned phases_run;

  binomial_tree_option_pricer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Bound the run: each item adds its own worst case to the budget.
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > budget) begin
        $display("timeout after %0d cycles with %0d results pending",
                 cycle_cnt, book.quotes.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Result sink: check each accepted result, then choose the next ready.
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        book.check_result(m_axis_tdata);
      end
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 14);
      end
    end
  end

  // Worst-case cycles of one item at the current tree size.
  function automatic longint tree_cycles();
    longint n;
    n = (book.steps > TREE_MAX) ? TREE_MAX : book.steps;
    return 4 * n * (n + 1) + 6 * n + 3;
  endfunction

  // d = 1/u in Q2.30.
  function automatic logic [31:0] inverse_q30(logic [31:0] u);
    logic [63:0] quot;
    quot = (64'd1 << 60) / {32'd0, u};
    return quot[31:0];
  endfunction

  function automatic logic [31:0] pick_spot();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return 32'h0;
    if (r < 10) return 32'hFFFF_FFFF;
    if (r < 35) return $urandom;
    // Most spots land within 40.0 of the strike.
    return book.strike + $urandom_range(0, 32'h0050_0000) - 32'h0028_0000;
  endfunction

  task automatic set_tree(logic [31:0] up, logic [31:0] down, logic [31:0] p,
                          logic [31:0] d);
    setting[CFG_UP]   = up;
    setting[CFG_DOWN] = down;
    setting[CFG_PROB] = p;
    setting[CFG_DISC] = d;
  endtask

  task automatic set_contract(logic [31:0] k, logic [31:0] n, logic call,
                              logic amer);
    setting[CFG_STRIKE]   = k;
    setting[CFG_STEPS]    = n;
    setting[CFG_CALL]     = {31'd0, call};
    setting[CFG_AMERICAN] = {31'd0, amer};
  endtask

  // Write all registers back to back; called at a clock edge while idle.
  task automatic load_config();
    for (int r = 0; r <= int'(CFG_AMERICAN); r++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= r[CFG_IDX_W-1:0];
      cfg_data_i <= setting[r];
      book.set_reg(r[CFG_IDX_W-1:0], setting[r]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    phases_run++;
  endtask

  // Offer one spot price; return at the edge that accepts it.
  task automatic send_spot(logic [31:0] spot);
    while (!steady && $urandom_range(99) < 14) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    budget += 3 * tree_cycles() + 2000;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= spot;
    do @(posedge clk_i); while (!s_axis_tready);
    book.note_spot(spot);
  endtask

  // Drop valid and wait until every owed result is back and the block is idle.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (book.quotes.size() != 0 || !s_axis_tready);
  endtask

  task automatic pick_settings();
    logic [31:0] up;
    logic [31:0] junk;
    int unsigned r;
    junk = $urandom;
    if ($urandom_range(4) == 0) begin
      set_tree($urandom, $urandom, $urandom, $urandom);
    end else begin
      up = 32'(ONE_Q30) + $urandom_range(0, 32'h0400_0000);
      set_tree(up, inverse_q30(up), $urandom_range(0, 32'(ONE_Q30)),
               32'(ONE_Q30) - $urandom_range(0, 32'h0040_0000));
      if ($urandom_range(7) == 0) setting[CFG_PROB] = $urandom;
      if ($urandom_range(7) == 0) setting[CFG_DISC] = $urandom;
    end
    // Mostly small trees keep the run short; now and then a zero-step tree.
    r = $urandom_range(99);
    if (r < 8) begin
      setting[CFG_STEPS] = 32'd0;
    end else if (r < 75) begin
      setting[CFG_STEPS] = $urandom_range(1, 10);
    end else if (r < 95) begin
      setting[CFG_STEPS] = $urandom_range(11, 24);
    end else begin
      setting[CFG_STEPS] = $urandom_range(25, 48);
    end
    setting[CFG_STRIKE]   = ($urandom_range(5) == 0) ? $urandom :
                            ($urandom_range(40, 160) << 16) | $urandom_range(0, 16'hFFFF);
    setting[CFG_CALL]     = $urandom_range(1);
    setting[CFG_AMERICAN] = $urandom_range(1);
    // Upper bits beyond each register's width must be dropped.
    if ($urandom_range(3) == 0) begin
      setting[CFG_STEPS]    = setting[CFG_STEPS] | {junk[31:11], 11'd0};
      setting[CFG_CALL]     = setting[CFG_CALL] | {junk[30:0], 1'b0};
      setting[CFG_AMERICAN] = setting[CFG_AMERICAN] | {junk[31:1], 1'b0};
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    steady     = 1'b0;
    hold_req   = 0;
    budget     = 20000;
    phases_run = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: one step, u = d = 1, call with zero strike.
    send_spot(32'h0000_0000);
    send_spot(32'hFFFF_FFFF);
    send_spot(32'h0064_8000);
    settle();

    // Zero-step put: payoff at the spot itself, no induction.
    set_tree(32'h4666_6666, inverse_q30(32'h4666_6666), 32'(HALF_Q30), 32'h3F5C_28F6);
    set_contract(32'h0064_0000, 32'd0, 1'b0, 1'b0);
    load_config();
    send_spot(32'h0000_0000);
    send_spot(32'h0032_0000);
    send_spot(32'h0096_0000);
    send_spot(32'hFFFF_FFFF);
    settle();

    // American put on a six-step tree; deep in the money it exercises early.
    set_contract(32'h0064_0000, 32'd6, 1'b0, 1'b1);
    load_config();
    send_spot(32'h0050_0000);
    send_spot(32'h0064_0000);
    send_spot(32'h0078_0000);
    settle();

    // American call with probability above one and zero discount.
    set_tree(32'h4333_3333, inverse_q30(32'h4333_3333), 32'h7FFF_FFFF, 32'd0);
    set_contract(32'h0032_0000, 32'd5, 1'b1, 1'b1);
    load_config();
    send_spot(32'h003C_0000);
    send_spot(32'h0028_0000);
    settle();

    // Flat tree: exercise only ties continuation, so no early exercise.
    set_tree(32'(ONE_Q30), 32'(ONE_Q30), 32'h1555_5555, 32'(ONE_Q30));
    set_contract(32'h000A_0000, 32'd4, 1'b1, 1'b1);
    load_config();
    send_spot(32'h001E_0000);
    settle();

    // Saturating factors, discount above one, largest strike.
    set_tree(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    set_contract(32'hFFFF_FFFF, 32'd3, 1'b0, 1'b1);
    load_config();
    send_spot(32'h0001_0000);
    send_spot(32'h1234_5678);
    settle();

    // Zero factors collapse every price to zero.
    set_tree(32'd0, 32'd0, 32'(ONE_Q30), 32'(ONE_Q30));
    set_contract(32'd0, 32'd2, 1'b1, 1'b1);
    load_config();
    send_spot(32'hFFFF_FFFF);
    settle();

    // Largest tree: a step count above the limit, held at the limit.
    set_tree(32'h4008_3127, inverse_q30(32'h4008_3127), 32'h1FFF_0000, 32'h3FFE_5C92);
    set_contract(32'h0064_0000, 32'h0000_07FF, 1'b0, 1'b1);
    load_config();
    send_spot(32'h0064_0000);
    settle();

    // Hold the sink off while the sender keeps offering: fill the output
    // register and the core, then stall the input.
    set_tree(32'h4666_6666, inverse_q30(32'h4666_6666), 32'(HALF_Q30), 32'h3F5C_28F6);
    set_contract(32'h0064_0000, 32'd4, 1'b1, 1'b0);
    load_config();
    steady   = 1'b1;
    hold_req = 800;
    budget  += 800;
    for (int i = 0; i < 6; i++) begin
      send_spot(32'h0050_0000 + (i << 18));
    end
    settle();
    steady = 1'b0;

    // Random settings, about ten items each; one phase runs without idling.
    for (int ph = 0; ph < 8; ph++) begin
      pick_settings();
      load_config();
      steady = (ph == 4);
      for (int i = 0; i < 10; i++) begin
        send_spot(pick_spot());
      end
      settle();
      steady = 1'b0;
    end

    // Let any stray result show up before closing.
    repeat (50) @(posedge clk_i);
    $display("Priced %0d spot prices under %0d register settings (trees of 0 to %0d steps,",
             book.priced, phases_run + 1, TREE_MAX);
    $display("calls and puts, European and American); %0d results checked in %0d cycles",
             book.checked, cycle_cnt);
    if (book.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", book.errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* binomial_tree_option_pricer_unit.f */
rtl/core/btop_pkg.sv
rtl/core/btop_mul.sv
rtl/core/binomial_tree_option_pricer_unit.sv
sim/tb_binomial_tree_option_pricer_unit.sv
